[hw/rtl/rkd_pkg.sv]
// Package for the recent-key duplicate filter.
// Holds shared widths, reset constants, mode codes and the table entry, input item and result types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rkd_pkg;

    localparam int KEY_W           = 32;
    localparam int STAMP_W         = 32;
    localparam int LIFE_W          = 32;
    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(10000);
    localparam logic [KEY_W-1:0]  INVALID_KEY    = '0;

    localparam logic MODE_CHECK = 1'b0;
    localparam logic MODE_PURGE = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic               mode;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic duplicate;
        logic table_full;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/rkd_if.sv]
// Valid/ready channel interfaces for the recent-key duplicate filter.
// Depends on rkd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rkd_in_if
    import rkd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] now_ms;

    modport source (output valid, output mode, output key, output now_ms, input ready);
    modport sink   (input valid, input mode, input key, input now_ms, output ready);
endinterface

interface rkd_out_if
    import rkd_pkg::*;
();
    logic valid;
    logic ready;
    logic duplicate;
    logic table_full;

    modport source (output valid, output duplicate, output table_full, input ready);
    modport sink   (input valid, input duplicate, input table_full, output ready);
endinterface

`default_nettype wire

[hw/rtl/rkd_table.sv]
// Entry memory of the duplicate filter: one write port, one read port,
// read data registered. Depends on rkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rkd_table
    import rkd_pkg::*;
#(
    parameter  int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_entry           i_wdata,
    input  wire logic             i_re,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_entry                o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/rkd_ctrl.sv]
// Sequencer of the duplicate filter: clearing pass, table walk for check and
// purge items, write-back, and the lifetime register. Depends on rkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rkd_ctrl
    import rkd_pkg::*;
#(
    parameter  int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [LIFE_W-1:0] i_cfg_wr_data,
    input  wire logic              i_in_valid,
    input  wire t_in_item          i_in_item,
    output logic                   o_in_ready,
    input  wire logic              i_slot_free,
    output logic                   o_done,
    output t_result                o_res,
    output logic                   o_mem_we,
    output logic [IDX_W-1:0]       o_mem_waddr,
    output t_entry                 o_mem_wdata,
    output logic                   o_mem_re,
    output logic [IDX_W-1:0]       o_mem_raddr,
    input  wire t_entry            i_mem_rdata
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_LAST  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic                r_mode, n_mode;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [STAMP_W-1:0]  r_now, n_now;
    logic                r_hit, n_hit;
    logic [IDX_W-1:0]    r_hit_idx, n_hit_idx;
    logic                r_free, n_free;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;
    logic [LIFE_W-1:0]   r_lifetime;

    logic [STAMP_W-1:0]  w_age;
    logic                w_expired;
    logic                w_accept;

    // wrap-safe age; a stamp in the future never expires
    assign w_age     = r_now - i_mem_rdata.stamp;
    assign w_expired = !w_age[STAMP_W-1] && (w_age > r_lifetime);
    assign w_accept  = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_mode      = r_mode;
        n_key       = r_key;
        n_now       = r_now;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        o_in_ready  = 1'b0;
        o_done      = 1'b0;
        o_res       = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx;

        // evaluate the entry returned by last cycle's read
        if (r_rd_vld) begin
            if (r_mode == MODE_PURGE) begin
                if (i_mem_rdata.valid && w_expired) begin
                    o_mem_we          = 1'b1;
                    o_mem_waddr       = r_rd_idx;
                    o_mem_wdata       = i_mem_rdata;
                    o_mem_wdata.valid = 1'b0;
                end
            end else begin
                if (i_mem_rdata.valid) begin
                    if (!r_hit && (i_mem_rdata.key == r_key)) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_rd_idx;
                    end
                end else if (!r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_rd_idx;
                end
            end
        end

        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx;
                o_mem_wdata = '0;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    n_mode  = i_in_item.mode;
                    n_key   = i_in_item.key;
                    n_now   = i_in_item.now_ms;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = r_idx;
                n_rd_vld    = 1'b1;
                n_rd_idx    = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_slot_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_mode == MODE_CHECK) begin
                        if (r_key == INVALID_KEY) begin
                            o_res.duplicate = 1'b1;
                        end else if (r_hit || r_free) begin
                            o_res.duplicate   = r_hit;
                            o_mem_we          = 1'b1;
                            o_mem_waddr       = r_hit ? r_hit_idx : r_free_idx;
                            o_mem_wdata.valid = 1'b1;
                            o_mem_wdata.key   = r_key;
                            o_mem_wdata.stamp = r_now;
                        end else begin
                            o_res.table_full = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_lifetime <= LIFETIME_RESET;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rd_vld <= n_rd_vld;
            if (i_cfg_wr_en) begin
                r_lifetime <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_now      <= n_now;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
    end

endmodule

`default_nettype wire

[hw/rtl/recent_key_dedup_filter.sv]
// Top level of the recent-key duplicate filter.
// Depends on rkd_pkg, rkd_if, rkd_table and rkd_ctrl.
//
// Keeps TABLE_DEPTH recently seen 32-bit keys with last-seen stamps in a
// single-port-read, single-port-write memory. A check beat (mode 0) reports
// whether its key is a duplicate (key 0 always is), renews a known key's
// stamp or stores a new key in the lowest free entry, and flags table_full
// when there is no room. A purge beat (mode 1) drops every entry whose
// wrap-safe age (now_ms - stamp, read as signed) exceeds lifetime_ms.
// Every item walks the whole table through the memory read port, one entry
// per cycle; the next item is accepted only once this one has passed the
// scan, last and done states, and the done state waits for the output
// register to drain. After reset a clearing pass invalidates all entries;
// the input is not ready during that pass, while lifetime writes are taken
// at any time.
// One result register sits on the output, so a result may wait there while
// the next item is accepted and walked.
`timescale 1ns / 1ps
`default_nettype none

module recent_key_dedup_filter
    import rkd_pkg::*;
#(
    parameter  int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [LIFE_W-1:0] i_cfg_wr_data,
    rkd_in_if.sink                 i_in,
    rkd_out_if.source              o_out
);

    t_in_item          w_item;
    logic              w_slot_free;
    logic              w_done;
    t_result           w_res;
    logic              w_mem_we;
    logic [IDX_W-1:0]  w_mem_waddr;
    t_entry            w_mem_wdata;
    logic              w_mem_re;
    logic [IDX_W-1:0]  w_mem_raddr;
    t_entry            w_mem_rdata;

    logic              r_out_valid;
    t_result           r_out_res;

    assign w_item.mode   = i_in.mode;
    assign w_item.key    = i_in.key;
    assign w_item.now_ms = i_in.now_ms;

    assign w_slot_free = !r_out_valid || o_out.ready;

    rkd_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in.valid),
        .i_in_item     (w_item),
        .o_in_ready    (i_in.ready),
        .i_slot_free   (w_slot_free),
        .o_done        (w_done),
        .o_res         (w_res),
        .o_mem_we      (w_mem_we),
        .o_mem_waddr   (w_mem_waddr),
        .o_mem_wdata   (w_mem_wdata),
        .o_mem_re      (w_mem_re),
        .o_mem_raddr   (w_mem_raddr),
        .i_mem_rdata   (w_mem_rdata)
    );

    rkd_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_res <= w_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.duplicate  = r_out_res.duplicate;
    assign o_out.table_full = r_out_res.table_full;

    a_done_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_slot_free)
        else $error("result produced while output register still occupied");

    a_no_done_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (!w_done && !i_in.ready))
        else $error("item finished or new item taken right after acceptance");

    a_dup_full_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !(w_res.duplicate && w_res.table_full))
        else $error("result marked both duplicate and table full");

    a_no_write_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_mem_we)
        else $error("table written while waiting for an item");

endmodule

`default_nettype wire
